>>> design/tea_pkg.sv
// Shared types and constants for the triangle edge adjacency block.
// No dependencies; every other design file refers to this package by scope.
package tea_pkg;

   localparam int MAX_TRIS     = 4096;
   localparam int TRI_IDX_BITS = $clog2(MAX_TRIS);
   localparam int CNT_BITS     = TRI_IDX_BITS + 1;
   localparam int VERT_BITS    = 16;
   localparam int QUERY_BITS   = 12;
   localparam int NBR_BITS     = 13;
   localparam int CMD_BITS     = 2;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = QPTR_BITS + 1;

   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd2;

   localparam logic [NBR_BITS-1:0] NBR_NONE = {NBR_BITS{1'b1}};

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_QUERY
   } op_type;

   // Three vertex indices of one triangle, corner zero in the low bits.
   typedef logic [2:0][VERT_BITS-1:0] tri_type;

   typedef struct packed {
      op_type                kind;
      tri_type               corners;
      logic [QUERY_BITS-1:0] query;
   } entry_type;

   typedef struct packed {
      logic                      status;
      logic [2:0][NBR_BITS-1:0]  nbr;
      logic [2:0]                dup;
   } result_type;

endpackage

>>> design/triangle_edge_adjacency_top.sv
// Top level of the triangle edge adjacency block: stream ports, front-end
// command queue and back-end scan engine. Uses tea_pkg, tea_front, tea_back.
//
// Commands arrive on the req_ stream and sit in a four-entry queue, so the
// block keeps accepting while the back end works. For a query of a stored
// triangle (count is the number of stored triangles) the back end reads the
// queried triangle, scans the stored triangles one per cycle through the
// single read port of the triangle memory, and then loads the result
// register. An out-of-range query goes straight to loading the result
// register. The memory needs no clearing pass; the stored count alone says
// which entries are valid. Results leave on the rsp_ stream from a register,
// and a waiting result stalls only the back end.
module triangle_edge_adjacency_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // corner_zero [15:0], corner_one [31:16], corner_two [47:32],
   // query_tri [59:48], zero fill [63:60]
   input  logic [63:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // nbr_edge_zero [12:0], nbr_edge_one [25:13], nbr_edge_two [38:26],
   // dup_edge_zero [39], dup_edge_one [40], dup_edge_two [41], zero fill [47:42]
   output logic [47:0] rsp_tdata,
   // status [0]
   output logic [0:0]  rsp_tuser
);

   tea_pkg::tri_type    in_corners;
   tea_pkg::entry_type  head;
   logic                head_valid;
   logic                head_pop;
   tea_pkg::result_type result;

   assign in_corners[0] = req_tdata[15:0];
   assign in_corners[1] = req_tdata[31:16];
   assign in_corners[2] = req_tdata[47:32];

   tea_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_corners (in_corners),
      .in_query   (req_tdata[59:48]),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   tea_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {6'b0, result.dup[2], result.dup[1], result.dup[0],
                       result.nbr[2], result.nbr[1], result.nbr[0]};
   assign rsp_tuser = result.status;

endmodule

>>> design/tea_front.sv
// Front end of the triangle edge adjacency block: accepts commands,
// classifies them and holds them in a short queue. Uses tea_pkg.
module tea_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [tea_pkg::CMD_BITS-1:0] in_cmd,
   input  tea_pkg::tri_type      in_corners,
   input  logic [tea_pkg::QUERY_BITS-1:0] in_query,
   output logic                  head_valid,
   output tea_pkg::entry_type    head,
   input  logic                  head_pop
);

   tea_pkg::entry_type                  queue_ff [tea_pkg::QUEUE_DEPTH];
   logic [tea_pkg::QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tea_pkg::QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tea_pkg::QCNT_BITS-1:0]       fill_ff, fill_in;
   tea_pkg::entry_type                  new_entry;
   logic                                keep;
   logic                                push;
   logic                                pop;

   assign in_ready   = (fill_ff != tea_pkg::QCNT_BITS'(tea_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   // Unused command codes are consumed here and never reach the back end.
   always_comb begin
      new_entry.corners = in_corners;
      new_entry.query   = in_query;
      new_entry.kind    = tea_pkg::OP_CLEAR;
      keep              = 1'b1;
      unique case (in_cmd)
         tea_pkg::CMD_CLEAR:  new_entry.kind = tea_pkg::OP_CLEAR;
         tea_pkg::CMD_APPEND: new_entry.kind = tea_pkg::OP_APPEND;
         tea_pkg::CMD_QUERY:  new_entry.kind = tea_pkg::OP_QUERY;
         default:             keep = 1'b0;
      endcase
   end

   assign push = in_valid && in_ready && keep;
   assign pop  = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

>>> design/tea_back.sv
// Back end of the triangle edge adjacency block: triangle memory, stored
// count, the scan engine for queries and the result register. Uses tea_pkg.
module tea_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  tea_pkg::entry_type head,
   output logic               head_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output tea_pkg::result_type out_result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QLOAD,
      ST_SCAN,
      ST_RESULT
   } state_type;

   tea_pkg::tri_type                    tri_mem [tea_pkg::MAX_TRIS];
   tea_pkg::tri_type                    rd_data_ff;
   logic [tea_pkg::TRI_IDX_BITS-1:0]    rd_addr;
   logic                                mem_we;

   state_type                           state_ff, state_in;
   logic [tea_pkg::CNT_BITS-1:0]        count_ff, count_in;
   logic [tea_pkg::QUERY_BITS-1:0]      qidx_ff, qidx_in;
   tea_pkg::tri_type                    qtri_ff, qtri_in;
   logic [tea_pkg::TRI_IDX_BITS-1:0]    cur_ff, cur_in;
   logic                                err_ff, err_in;
   logic [2:0]                          found_ff, found_in;
   logic [2:0][tea_pkg::TRI_IDX_BITS-1:0] nbr_ff, nbr_in;
   logic [2:0]                          dup_ff, dup_in;
   logic                                out_valid_ff, out_valid_in;
   tea_pkg::result_type                 out_result_ff, out_result_in;

   logic [2:0][2:0]                     eq;
   logic [2:0]                          rev_hit;
   logic [2:0]                          dup_hit;
   logic                                self_tri;

   function automatic int unsigned nxt(input int unsigned k);
      return (k == 2) ? 0 : k + 1;
   endfunction

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

   // eq[m][n]: corner m of the triangle being scanned equals corner n of
   // the queried triangle. Edge matches are formed from these nine compares.
   always_comb begin
      for (int m = 0; m < 3; m++) begin
         for (int n = 0; n < 3; n++) begin
            eq[m][n] = (rd_data_ff[m] == qtri_ff[n]);
         end
      end
      self_tri = (tea_pkg::QUERY_BITS'(cur_ff) == qidx_ff);
      for (int k = 0; k < 3; k++) begin
         rev_hit[k] = 1'b0;
         dup_hit[k] = 1'b0;
         for (int j = 0; j < 3; j++) begin
            if (eq[j][nxt(k)] && eq[nxt(j)][k]) begin
               rev_hit[k] = 1'b1;
            end
            if (eq[j][k] && eq[nxt(j)][nxt(k)] && !(self_tri && (j == k))) begin
               dup_hit[k] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      qidx_in       = qidx_ff;
      qtri_in       = qtri_ff;
      cur_in        = cur_ff;
      err_in        = err_ff;
      found_in      = found_ff;
      nbr_in        = nbr_ff;
      dup_in        = dup_ff;
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      head_pop      = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = cur_ff + 1'b1;

      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = head.query[tea_pkg::TRI_IDX_BITS-1:0];
            if (head_valid) begin
               head_pop = 1'b1;
               unique case (head.kind)
                  tea_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  tea_pkg::OP_APPEND: begin
                     // A full store ignores the append.
                     if (count_ff != tea_pkg::CNT_BITS'(tea_pkg::MAX_TRIS)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  tea_pkg::OP_QUERY: begin
                     qidx_in = head.query;
                     if (tea_pkg::CNT_BITS'(head.query) >= count_ff) begin
                        err_in   = 1'b1;
                        state_in = ST_RESULT;
                     end else begin
                        err_in   = 1'b0;
                        state_in = ST_QLOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_QLOAD: begin
            qtri_in  = rd_data_ff;
            rd_addr  = '0;
            cur_in   = '0;
            found_in = '0;
            dup_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            for (int k = 0; k < 3; k++) begin
               if (!found_ff[k] && rev_hit[k]) begin
                  found_in[k] = 1'b1;
                  nbr_in[k]   = cur_ff;
               end
               if (dup_hit[k]) begin
                  dup_in[k] = 1'b1;
               end
            end
            if (({1'b0, cur_ff} + 1'b1) == count_ff) begin
               state_in = ST_RESULT;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         ST_RESULT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in         = 1'b1;
               out_result_in.status = err_ff;
               for (int k = 0; k < 3; k++) begin
                  if (!err_ff && found_ff[k]) begin
                     out_result_in.nbr[k] = tea_pkg::NBR_BITS'(nbr_ff[k]);
                  end else begin
                     out_result_in.nbr[k] = tea_pkg::NBR_NONE;
                  end
                  out_result_in.dup[k] = !err_ff && dup_ff[k];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      qidx_ff       <= qidx_in;
      qtri_ff       <= qtri_in;
      cur_ff        <= cur_in;
      err_ff        <= err_in;
      found_ff      <= found_in;
      nbr_ff        <= nbr_in;
      dup_ff        <= dup_in;
      out_result_ff <= out_result_in;
   end

   // Triangle memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tri_mem[count_ff[tea_pkg::TRI_IDX_BITS-1:0]] <= head.corners;
      end
      rd_data_ff <= tri_mem[rd_addr];
   end

endmodule

>>> verif/triangle_edge_adjacency_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for triangle_edge_adjacency_top: drives commands on the req_
// stream and checks every query result against a neighbour predictor.
// Depends on tea_pkg and the RTL.

// Tracks the stored triangles as transfers are accepted and holds the neighbour
// results that the block owes.
class adjacency_board;
   tea_pkg::tri_type          store [tea_pkg::MAX_TRIS];
   int unsigned               count;
   tea_pkg::result_type       adjacency_q [$];
   int                        errors;

   function new();
      count  = 0;
      errors = 0;
   endfunction

   function int pending();
      return adjacency_q.size();
   endfunction

   function tea_pkg::result_type neighbours_of(int unsigned q);
      tea_pkg::result_type            r;
      logic [tea_pkg::VERT_BITS-1:0]  a, b, s, e;
      bit                             found;
      int                             k, t, j;
      r.status = 1'b0;
      if (q >= count) begin
         r.status = 1'b1;
         r.nbr    = {3{tea_pkg::NBR_NONE}};
         r.dup    = '0;
         return r;
      end
      for (k = 0; k < 3; k++) begin
         a          = store[q][k];
         b          = store[q][(k + 1) % 3];
         found      = 1'b0;
         r.nbr[k]   = tea_pkg::NBR_NONE;
         r.dup[k]   = 1'b0;
         for (t = 0; t < count; t++) begin
            for (j = 0; j < 3; j++) begin
               s = store[t][j];
               e = store[t][(j + 1) % 3];
               // The lowest index holding the reversed edge wins.
               if (!found && s == b && e == a) begin
                  found    = 1'b1;
                  r.nbr[k] = tea_pkg::NBR_BITS'(t);
               end
               if (!(t == q && j == k) && s == a && e == b) begin
                  r.dup[k] = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   function void note_request(logic [tea_pkg::CMD_BITS-1:0] cmd,
                              tea_pkg::tri_type corners,
                              logic [tea_pkg::QUERY_BITS-1:0] query);
      case (cmd)
         tea_pkg::CMD_CLEAR: begin
            count = 0;
         end
         tea_pkg::CMD_APPEND: begin
            // An append to a full store is dropped.
            if (count < tea_pkg::MAX_TRIS) begin
               store[count] = corners;
               count++;
            end
         end
         tea_pkg::CMD_QUERY: begin
            adjacency_q.insert(adjacency_q.size(), neighbours_of(query));
         end
         default: begin
         end
      endcase
   endfunction

   function void check_response(logic [47:0] data, logic status_bit);
      tea_pkg::result_type           want;
      logic [tea_pkg::NBR_BITS-1:0]  got_nbr;
      int                            k;
      if (adjacency_q.size() == 0) begin
         errors++;
         $display("%0t: result with no query outstanding, data %h status %0b",
                  $time, data, status_bit);
         return;
      end
      want = adjacency_q.pop_front();
      if (status_bit !== want.status) begin
         errors++;
         $display("%0t: status expected %0b actual %0b", $time, want.status, status_bit);
      end
      for (k = 0; k < 3; k++) begin
         got_nbr = data[tea_pkg::NBR_BITS*k +: tea_pkg::NBR_BITS];
         if (got_nbr !== want.nbr[k]) begin
            errors++;
            $display("%0t: neighbour across edge %0d expected %0d actual %0d", $time, k,
                     $signed(want.nbr[k]), $signed(got_nbr));
         end
         if (data[3*tea_pkg::NBR_BITS + k] !== want.dup[k]) begin
            errors++;
            $display("%0t: duplicate flag of edge %0d expected %0b actual %0b", $time, k,
                     want.dup[k], data[3*tea_pkg::NBR_BITS + k]);
         end
      end
   endfunction
endclass

module triangle_edge_adjacency_top_tb;

   localparam logic [tea_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int                           SETTLE_CYCLES = 100;
   localparam int                           HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   adjacency_board                 sb = new();
   int                             send_idle_pct = 0;
   int                             stall_pct = 0;
   int                             hold_requests = 0;
   logic [tea_pkg::VERT_BITS-1:0]  vertex_base = '0;
   tea_pkg::tri_type               last_tri;
   bit                             have_last = 1'b0;

   triangle_edge_adjacency_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[triangle_edge_adjacency_top] ERROR");
      $finish;
   end

   // Result side: random stalls, or a long hold-off counted here whenever one
   // is requested.
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata, rsp_tuser[0]);
      end
   end

   task automatic send_item(input logic [tea_pkg::CMD_BITS-1:0] cmd,
                            input tea_pkg::tri_type corners,
                            input logic [tea_pkg::QUERY_BITS-1:0] query);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, query, corners};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, corners, query);
   endtask

   function automatic tea_pkg::tri_type noise_corners();
      return tea_pkg::tri_type'({$urandom(), $urandom()});
   endfunction

   task automatic send_append(input logic [tea_pkg::VERT_BITS-1:0] c0, c1, c2);
      tea_pkg::tri_type t;
      t = {c2, c1, c0};
      send_item(tea_pkg::CMD_APPEND, t, tea_pkg::QUERY_BITS'($urandom()));
      last_tri  = t;
      have_last = 1'b1;
   endtask

   task automatic send_query(input logic [tea_pkg::QUERY_BITS-1:0] q);
      send_item(tea_pkg::CMD_QUERY, noise_corners(), q);
   endtask

   task automatic send_clear();
      send_item(tea_pkg::CMD_CLEAR, noise_corners(), tea_pkg::QUERY_BITS'($urandom()));
      vertex_base = tea_pkg::VERT_BITS'($urandom());
      have_last   = 1'b0;
   endtask

   function automatic logic [tea_pkg::VERT_BITS-1:0] pool_vertex();
      return vertex_base ^ tea_pkg::VERT_BITS'($urandom_range(5));
   endfunction

   // Mostly mesh-like triangles from a small vertex pool, often glued to the
   // previous one across a reversed edge so that neighbours and duplicates show up.
   task automatic send_mesh_triangle();
      int k;
      if (have_last && $urandom_range(1)) begin
         k = $urandom_range(2);
         send_append(last_tri[(k + 1) % 3], last_tri[k], pool_vertex());
      end else begin
         send_append(pool_vertex(), pool_vertex(), pool_vertex());
      end
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int n_items);
      int sent;
      int r;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(99);
         if (r < 6 || sb.count > 40) begin
            send_clear();
            sent++;
         end else if (r < 50) begin
            send_mesh_triangle();
            sent++;
         end else if (r < 85) begin
            if (sb.count > 0) begin
               send_query(tea_pkg::QUERY_BITS'($urandom_range(sb.count - 1)));
            end else begin
               send_query(tea_pkg::QUERY_BITS'($urandom()));
            end
            sent++;
         end else if (r < 92) begin
            send_query(tea_pkg::QUERY_BITS'($urandom()));
            sent++;
         end else if (r < 96) begin
            send_append(tea_pkg::VERT_BITS'($urandom()), tea_pkg::VERT_BITS'($urandom()),
                        tea_pkg::VERT_BITS'($urandom()));
            sent++;
         end else begin
            send_item(CMD_UNUSED, noise_corners(), tea_pkg::QUERY_BITS'($urandom()));
         end
      end
   endtask

   initial begin
      int i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = tea_pkg::CMD_CLEAR;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, reversed and repeated edges, degenerate and extreme corners.
      send_clear();
      send_query(tea_pkg::QUERY_BITS'(0));
      send_append(16'd1, 16'd2, 16'd3);
      send_append(16'd3, 16'd2, 16'd1);
      send_append(16'd1, 16'd2, 16'd4);
      send_append(16'd5, 16'd5, 16'd7);
      send_append(16'hFFFF, 16'h0000, 16'hFFFF);
      send_append(16'h0000, 16'hFFFF, 16'h0000);
      send_item(CMD_UNUSED, noise_corners(), tea_pkg::QUERY_BITS'($urandom()));
      for (i = 0; i < 6; i++) send_query(tea_pkg::QUERY_BITS'(i));
      send_query(tea_pkg::QUERY_BITS'(6));
      send_query({tea_pkg::QUERY_BITS{1'b1}});
      send_clear();
      send_query(tea_pkg::QUERY_BITS'(0));
      send_append(16'd7, 16'd8, 16'd9);
      send_query(tea_pkg::QUERY_BITS'(0));
      wait_drain();

      // Back pressure: results held back while queries keep coming.
      send_append(16'd9, 16'd8, 16'd10);
      send_append(16'd10, 16'd8, 16'd7);
      hold_requests++;
      for (i = 0; i < 12; i++) send_query(tea_pkg::QUERY_BITS'($urandom_range(3)));
      wait_drain();
      send_clear();

      send_idle_pct = 0;
      stall_pct     = 0;
      run_random(26);
      send_idle_pct = 81;
      run_random(26);
      send_idle_pct = 0;
      stall_pct     = 81;
      run_random(26);
      send_idle_pct = 38;
      stall_pct     = 38;
      run_random(26);
      wait_drain();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[triangle_edge_adjacency_top] OK");
      end else begin
         $display("[triangle_edge_adjacency_top] ERROR");
      end
      $finish;
   end

endmodule

>>> triangle_edge_adjacency_top.f
design/tea_pkg.sv
design/tea_front.sv
design/tea_back.sv
design/triangle_edge_adjacency_top.sv
verif/triangle_edge_adjacency_top_tb.sv
